[design/ppa_pkg.sv]
`default_nettype none
package ppa_pkg;

  localparam int PAGE_BYTES_DEF  = 4096;
  localparam int MAX_REGIONS_DEF = 16;
  localparam int MAX_PAGES_DEF   = 64;

  typedef enum logic [1:0] {
    OP_DECLARE = 2'd0,
    OP_RESERVE = 2'd1,
    OP_ALLOC   = 2'd2,
    OP_FREE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NOMEM    = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] addr;
    logic [31:0] region_length;
    logic [31:0] range_end;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] page_addr;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_R_READ,
    S_R_CHECK,
    S_R_SHIFT_RD,
    S_R_SHIFT_WR,
    S_APPEND_LO,
    S_APPEND_HI,
    S_POP,
    S_P_READ,
    S_P_CHECK,
    S_P_SHIFT_RD,
    S_P_SHIFT_WR,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

[design/physical_page_allocator.sv]
// Physical page allocator.
// Request channel: req is taken at a rising edge with start high and busy low.
// Result channel: done is high for exactly one cycle with rsp valid; the
// receiver cannot stall it, so the result must be taken in that cycle.
// One request gives one result; busy stays high from the transfer until the
// cycle after done, and start is ignored meanwhile.
// Steps per request: declare goes straight to the result, and allocate
// from the freed stack pops its top entry. Reserve and carving allocate
// walk the region table entry by entry, reading and then checking each;
// reserve then moves later entries down, a read and a write per entry,
// and appends up to two pieces. Free walks the allocated list and
// compacts it the same way. Every walk goes through the single read port
// of a table memory with registered read data. PAGE_BYTES must be a power
// of two.
// Reset empties all three tables by clearing their counts; no clearing pass.
`default_nettype none
module physical_page_allocator import ppa_pkg::*; #(
  parameter int PAGE_BYTES  = PAGE_BYTES_DEF,
  parameter int MAX_REGIONS = MAX_REGIONS_DEF,
  parameter int MAX_PAGES   = MAX_PAGES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire req_t req,
  output logic      busy,
  output logic      done,
  output rsp_t      rsp
);

  localparam int RAW = $clog2(MAX_REGIONS);
  localparam int RCW = $clog2(MAX_REGIONS + 1);
  localparam int PAW = $clog2(MAX_PAGES);
  localparam int PCW = $clog2(MAX_PAGES + 1);
  localparam logic [32:0] PB    = 33'(PAGE_BYTES);
  localparam logic [32:0] PMASK = 33'(PAGE_BYTES - 1);
  localparam logic [32:0] TOP32 = 33'h1_0000_0000;

  state_t state, state_next;
  req_t   req_q;
  logic [RCW-1:0] rcount, rcount_next, ridx, ridx_next;
  logic [PCW-1:0] fcount, fcount_next, acount, acount_next, pidx, pidx_next;
  status_t status, status_next;
  logic [31:0] page, page_next;
  logic [31:0] lo_base, lo_base_next, lo_len, lo_len_next;
  logic [31:0] hi_base, hi_base_next, hi_len, hi_len_next;

  logic           r_we;
  logic [RAW-1:0] r_waddr, r_raddr;
  logic [63:0]    r_wdata, r_rdata;
  logic           a_we;
  logic [PAW-1:0] a_waddr, a_raddr;
  logic [31:0]    a_wdata, a_rdata;
  logic           f_we;
  logic [PAW-1:0] f_waddr, f_raddr;
  logic [31:0]    f_wdata, f_rdata;

  ppa_ram #(.WIDTH(64), .DEPTH(MAX_REGIONS)) u_region (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr), .rdata(r_rdata)
  );
  ppa_ram #(.WIDTH(32), .DEPTH(MAX_PAGES)) u_alloc (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr(a_raddr), .rdata(a_rdata)
  );
  ppa_ram #(.WIDTH(32), .DEPTH(MAX_PAGES)) u_freed (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata)
  );

  // region entry under test
  logic [31:0] eb, el, rsv_end, first_len, second_len;
  logic [32:0] top, aligned, gap, carve_len, carve_end;
  logic        contain, fits;
  logic        r_more, r_shift_more, p_more, p_shift_more;
  logic        region_full, pages_full, freed_full, page_hit;

  assign eb         = r_rdata[63:32];
  assign el         = r_rdata[31:0];
  assign top        = {1'b0, eb} + {1'b0, el};
  assign rsv_end    = (req_q.range_end < req_q.addr) ? req_q.addr : req_q.range_end;
  assign contain    = (req_q.addr >= eb) && ({1'b0, req_q.addr} < top);
  assign first_len  = req_q.addr - eb;
  assign second_len = ({1'b0, rsv_end} < top) ? 32'(top - {1'b0, rsv_end}) : 32'd0;
  assign aligned    = ({1'b0, eb} + PMASK) & ~PMASK;
  assign gap        = aligned - {1'b0, eb};
  assign carve_len  = {1'b0, el} - gap;
  assign carve_end  = aligned + PB;
  assign fits       = (gap <= {1'b0, el}) && (carve_len >= PB) && (carve_end <= TOP32);

  assign r_more       = (RCW'(ridx + 1'b1) < rcount);
  assign r_shift_more = ((RCW + 1)'(ridx) + 2'd2 < (RCW + 1)'(rcount));
  assign p_more       = (PCW'(pidx + 1'b1) < acount);
  assign p_shift_more = ((PCW + 1)'(pidx) + 2'd2 < (PCW + 1)'(acount));
  assign region_full  = (rcount >= RCW'(MAX_REGIONS));
  assign pages_full   = (acount >= PCW'(MAX_PAGES));
  assign freed_full   = (fcount >= PCW'(MAX_PAGES));
  assign page_hit     = (a_rdata == req_q.addr);

  assign f_raddr = PAW'(fcount - 1'b1);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (req.op)
            OP_DECLARE: state_next = S_DONE;
            OP_RESERVE: state_next = (rcount == '0) ? S_DONE : S_R_READ;
            OP_ALLOC: begin
              if (pages_full) state_next = S_DONE;
              else if (fcount != '0) state_next = S_POP;
              else state_next = (rcount == '0) ? S_DONE : S_R_READ;
            end
            default: state_next = (acount == '0) ? S_DONE : S_P_READ;
          endcase
        end
      end
      S_R_READ: state_next = S_R_CHECK;
      S_R_CHECK: begin
        if (req_q.op == OP_RESERVE && contain) begin
          if (first_len != '0 && second_len != '0 && region_full) state_next = S_DONE;
          else state_next = r_more ? S_R_SHIFT_RD : S_APPEND_LO;
        end else if (req_q.op == OP_ALLOC && fits) begin
          state_next = S_DONE;
        end else begin
          state_next = r_more ? S_R_READ : S_DONE;
        end
      end
      S_R_SHIFT_RD: state_next = S_R_SHIFT_WR;
      S_R_SHIFT_WR: state_next = r_shift_more ? S_R_SHIFT_RD : S_APPEND_LO;
      S_APPEND_LO:  state_next = S_APPEND_HI;
      S_APPEND_HI:  state_next = S_DONE;
      S_POP:        state_next = S_DONE;
      S_P_READ:     state_next = S_P_CHECK;
      S_P_CHECK: begin
        if (page_hit) state_next = (!freed_full && p_more) ? S_P_SHIFT_RD : S_DONE;
        else state_next = p_more ? S_P_READ : S_DONE;
      end
      S_P_SHIFT_RD: state_next = S_P_SHIFT_WR;
      S_P_SHIFT_WR: state_next = p_shift_more ? S_P_SHIFT_RD : S_DONE;
      S_DONE:       state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rcount_next  = rcount;
    fcount_next  = fcount;
    acount_next  = acount;
    ridx_next    = ridx;
    pidx_next    = pidx;
    status_next  = status;
    page_next    = page;
    lo_base_next = lo_base;
    lo_len_next  = lo_len;
    hi_base_next = hi_base;
    hi_len_next  = hi_len;
    r_we    = 1'b0;
    r_waddr = ridx[RAW-1:0];
    r_wdata = {req.addr, req.region_length};
    r_raddr = ridx[RAW-1:0];
    a_we    = 1'b0;
    a_waddr = acount[PAW-1:0];
    a_wdata = f_rdata;
    a_raddr = pidx[PAW-1:0];
    f_we    = 1'b0;
    f_waddr = fcount[PAW-1:0];
    f_wdata = req_q.addr;
    case (state)
      S_IDLE: begin
        ridx_next = '0;
        pidx_next = '0;
        page_next = '0;
        if (start) begin
          case (req.op)
            OP_DECLARE: begin
              if (region_full) begin
                status_next = STAT_FULL;
              end else begin
                r_we        = 1'b1;
                r_waddr     = rcount[RAW-1:0];
                rcount_next = RCW'(rcount + 1'b1);
                status_next = STAT_OK;
              end
            end
            OP_RESERVE: status_next = STAT_NOTFOUND;
            OP_ALLOC:   status_next = pages_full ? STAT_FULL : STAT_NOMEM;
            default:    status_next = STAT_NOTFOUND;
          endcase
        end
      end
      S_R_CHECK: begin
        if (req_q.op == OP_RESERVE && contain) begin
          if (first_len != '0 && second_len != '0 && region_full) begin
            status_next = STAT_FULL;
          end else begin
            status_next  = STAT_OK;
            lo_base_next = eb;
            lo_len_next  = first_len;
            hi_base_next = rsv_end;
            hi_len_next  = second_len;
            if (!r_more) rcount_next = RCW'(rcount - 1'b1);
          end
        end else if (req_q.op == OP_ALLOC && fits) begin
          r_we        = 1'b1;
          r_wdata     = {carve_end[31:0], 32'(carve_len - PB)};
          a_we        = 1'b1;
          a_wdata     = aligned[31:0];
          acount_next = PCW'(acount + 1'b1);
          page_next   = aligned[31:0];
          status_next = STAT_OK;
        end else if (r_more) begin
          ridx_next = RCW'(ridx + 1'b1);
        end
      end
      S_R_SHIFT_RD: r_raddr = RAW'(ridx + 1'b1);
      S_R_SHIFT_WR: begin
        r_we      = 1'b1;
        r_wdata   = r_rdata;
        ridx_next = RCW'(ridx + 1'b1);
        if (!r_shift_more) rcount_next = RCW'(rcount - 1'b1);
      end
      S_APPEND_LO: begin
        r_waddr = rcount[RAW-1:0];
        r_wdata = {lo_base, lo_len};
        if (lo_len != '0) begin
          r_we        = 1'b1;
          rcount_next = RCW'(rcount + 1'b1);
        end
      end
      S_APPEND_HI: begin
        r_waddr = rcount[RAW-1:0];
        r_wdata = {hi_base, hi_len};
        if (hi_len != '0) begin
          r_we        = 1'b1;
          rcount_next = RCW'(rcount + 1'b1);
        end
      end
      S_POP: begin
        a_we        = 1'b1;
        acount_next = PCW'(acount + 1'b1);
        fcount_next = PCW'(fcount - 1'b1);
        page_next   = f_rdata;
        status_next = STAT_OK;
      end
      S_P_CHECK: begin
        if (page_hit) begin
          if (freed_full) begin
            status_next = STAT_FULL;
          end else begin
            f_we        = 1'b1;
            fcount_next = PCW'(fcount + 1'b1);
            status_next = STAT_OK;
            if (!p_more) acount_next = PCW'(acount - 1'b1);
          end
        end else if (p_more) begin
          pidx_next = PCW'(pidx + 1'b1);
        end
      end
      S_P_SHIFT_RD: a_raddr = PAW'(pidx + 1'b1);
      S_P_SHIFT_WR: begin
        a_we      = 1'b1;
        a_waddr   = pidx[PAW-1:0];
        a_wdata   = a_rdata;
        pidx_next = PCW'(pidx + 1'b1);
        if (!p_shift_more) acount_next = PCW'(acount - 1'b1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rcount <= '0;
      fcount <= '0;
      acount <= '0;
    end else begin
      state  <= state_next;
      rcount <= rcount_next;
      fcount <= fcount_next;
      acount <= acount_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      req_q <= req;
    end
    ridx    <= ridx_next;
    pidx    <= pidx_next;
    status  <= status_next;
    page    <= page_next;
    lo_base <= lo_base_next;
    lo_len  <= lo_len_next;
    hi_base <= hi_base_next;
    hi_len  <= hi_len_next;
  end

  assign busy           = (state != S_IDLE);
  assign done           = (state == S_DONE);
  assign rsp.status     = status;
  assign rsp.page_addr  = page;

`ifndef SYNTHESIS
  a_region_bound: assert property (@(posedge clk) disable iff (rst)
    rcount <= RCW'(MAX_REGIONS)) else $error("region count beyond table");
  a_page_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |->
    ((PCW + 1)'(fcount) + (PCW + 1)'(acount) <= (PCW + 1)'(MAX_PAGES)))
    else $error("freed plus allocated pages beyond capacity");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");
  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(done)) else $error("request ended without result");
  a_ok_page: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != STAT_OK) |-> (rsp.page_addr == '0))
    else $error("failed request carries a page");
`endif

endmodule
`default_nettype wire

[design/ppa_ram.sv]
`default_nettype none
module ppa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
